// ===== rtl/core/cau_pkg.sv =====
// Package for the complex arithmetic unit: action codes, payload structs and the
// sideband struct that rides along the divider chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [2:0] ACT_CMP = 3'd0;
    localparam logic [2:0] ACT_ADD = 3'd1;
    localparam logic [2:0] ACT_SUB = 3'd2;
    localparam logic [2:0] ACT_MUL = 3'd3;
    localparam logic [2:0] ACT_DIV = 3'd4;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               equal;
        logic               div_zero;
        logic               overflow;
    } t_out_item;

    // Per-item control and finished result for non-divide actions
    typedef struct packed {
        logic               is_div;
        logic               dz;
        logic               neg_re;
        logic               neg_im;
        logic               big_re;
        logic               big_im;
        logic               eq;
        logic               ovf;
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/core/cau_div_cell.sv =====
// One restoring-division cell: settles one quotient bit for both the real and
// imaginary quotients and hands everything to the next cell. Uses cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_div_cell
    import cau_pkg::*;
#(
    parameter int DW    = DATA_WIDTH_DEF,
    parameter int PW    = 2 * DW,
    parameter int RW    = PW + 2,
    parameter int SHIFT = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire t_side         i_side,
    input  wire logic [PW-1:0] i_den,
    input  wire logic [RW-1:0] i_rem_re,
    input  wire logic [RW-1:0] i_rem_im,
    input  wire logic [DW:0]   i_q_re,
    input  wire logic [DW:0]   i_q_im,
    output logic               o_valid,
    output t_side              o_side,
    output logic [PW-1:0]      o_den,
    output logic [RW-1:0]      o_rem_re,
    output logic [RW-1:0]      o_rem_im,
    output logic [DW:0]        o_q_re,
    output logic [DW:0]        o_q_im
);

    logic [RW-1:0] den_sh;
    logic          ge_re, ge_im;
    logic [RW-1:0] n_rem_re, n_rem_im;

    assign den_sh   = RW'(i_den) << SHIFT;
    assign ge_re    = i_rem_re >= den_sh;
    assign ge_im    = i_rem_im >= den_sh;
    assign n_rem_re = ge_re ? (i_rem_re - den_sh) : i_rem_re;
    assign n_rem_im = ge_im ? (i_rem_im - den_sh) : i_rem_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side   <= i_side;
            o_den    <= i_den;
            o_rem_re <= n_rem_re;
            o_rem_im <= n_rem_im;
            o_q_re   <= {i_q_re[DW-1:0], ge_re};
            o_q_im   <= {i_q_im[DW-1:0], ge_im};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Complex ALU: compare, add, subtract, multiply, divide on signed fixed point.
// Throughput one item per cycle while no result is stalled at the output; depth
// is set by the divider chain, one cell per quotient bit.
// The whole pipeline holds while a finished result is stalled at the output.
// Synchronous active-low reset clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_data,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_data
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int PW = 2 * DW;
    localparam int RW = PW + FB + DW + 2;
    localparam int NC = DW + 1;

    localparam logic signed [PW:0] SMAX = (PW+1)'((65'sd1 <<< (DW - 1)) - 65'sd1);
    localparam logic signed [PW:0] SMIN = -SMAX - (PW+1)'(1);

    // bit 32 flags saturation, low bits are the result sign-extended to 32
    function automatic logic [32:0] sat(input logic signed [PW:0] v);
        logic signed [PW:0] c;
        logic               o;
        c = v;
        o = 1'b0;
        if (v > SMAX) begin
            c = SMAX;
            o = 1'b1;
        end else if (v < SMIN) begin
            c = SMIN;
            o = 1'b1;
        end
        return {o, 32'(signed'(c[DW-1:0]))};
    endfunction

    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // stage 1: capture
    logic     r_v1;
    t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in <= i_data;
        end
    end

    // stage 2: products, simple actions finished
    logic signed [DW-1:0] ar, ai, br, bi;
    assign ar = signed'(r_in.a_re[DW-1:0]);
    assign ai = signed'(r_in.a_im[DW-1:0]);
    assign br = signed'(r_in.b_re[DW-1:0]);
    assign bi = signed'(r_in.b_im[DW-1:0]);

    t_side       n_side2;
    logic [32:0] s1_re, s1_im;
    logic        is_mul1;

    always_comb begin
        n_side2 = '0;
        is_mul1 = 1'b0;
        s1_re   = '0;
        s1_im   = '0;
        case (r_in.action)
            ACT_CMP: begin
                n_side2.res_re = 32'(br);
                n_side2.res_im = 32'(bi);
                n_side2.eq     = (ar == br) && (ai == bi);
            end
            ACT_ADD: begin
                s1_re = sat((PW+1)'(ar) + (PW+1)'(br));
                s1_im = sat((PW+1)'(ai) + (PW+1)'(bi));
                n_side2.res_re = s1_re[31:0];
                n_side2.res_im = s1_im[31:0];
                n_side2.ovf    = s1_re[32] | s1_im[32];
            end
            ACT_SUB: begin
                s1_re = sat((PW+1)'(ar) - (PW+1)'(br));
                s1_im = sat((PW+1)'(ai) - (PW+1)'(bi));
                n_side2.res_re = s1_re[31:0];
                n_side2.res_im = s1_im[31:0];
                n_side2.ovf    = s1_re[32] | s1_im[32];
            end
            ACT_MUL: is_mul1 = 1'b1;
            ACT_DIV: n_side2.is_div = 1'b1;
            default: ;
        endcase
    end

    logic                 r_v2, r_mul2;
    t_side                r_side2;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side2 <= n_side2;
            r_mul2  <= is_mul1;
            r_p_rr  <= ar * br;
            r_p_ii  <= ai * bi;
            r_p_ri  <= ar * bi;
            r_p_ir  <= ai * br;
            r_sq_r  <= br * br;
            r_sq_i  <= bi * bi;
        end
    end

    // stage 3: sums; multiply finished
    logic signed [PW:0] m_re, m_im;
    logic [32:0]        s2_re, s2_im;
    t_side              n_side3;

    assign m_re  = (PW+1)'(r_p_rr) - (PW+1)'(r_p_ii);
    assign m_im  = (PW+1)'(r_p_ri) + (PW+1)'(r_p_ir);
    assign s2_re = sat(m_re >>> FB);
    assign s2_im = sat(m_im >>> FB);

    always_comb begin
        n_side3 = r_side2;
        if (r_mul2) begin
            n_side3.res_re = s2_re[31:0];
            n_side3.res_im = s2_im[31:0];
            n_side3.ovf    = s2_re[32] | s2_im[32];
        end
    end

    logic               r_v3;
    t_side              r_side3;
    logic signed [PW:0] r_num_re, r_num_im;
    logic [PW-1:0]      r_den3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side3  <= n_side3;
            r_num_re <= (PW+1)'(r_p_rr) + (PW+1)'(r_p_ii);
            r_num_im <= (PW+1)'(r_p_ir) - (PW+1)'(r_p_ri);
            r_den3   <= unsigned'(r_sq_r) + unsigned'(r_sq_i);
        end
    end

    // stage 4: magnitudes, scaled numerators, range check ahead of the chain
    logic [PW:0]   mag_re_w, mag_im_w;
    logic [RW-1:0] num_re_sh, num_im_sh, den_top;
    t_side         n_side4;

    assign mag_re_w  = r_num_re[PW] ? unsigned'(-r_num_re) : unsigned'(r_num_re);
    assign mag_im_w  = r_num_im[PW] ? unsigned'(-r_num_im) : unsigned'(r_num_im);
    assign num_re_sh = RW'(mag_re_w[PW-1:0]) << FB;
    assign num_im_sh = RW'(mag_im_w[PW-1:0]) << FB;
    assign den_top   = RW'(r_den3) << NC;

    always_comb begin
        n_side4        = r_side3;
        n_side4.neg_re = r_num_re[PW];
        n_side4.neg_im = r_num_im[PW];
        n_side4.big_re = num_re_sh >= den_top;
        n_side4.big_im = num_im_sh >= den_top;
        n_side4.dz     = r_side3.is_div && (r_den3 == '0);
    end

    logic          c_v    [NC+1];
    t_side         c_side [NC+1];
    logic [PW-1:0] c_den  [NC+1];
    logic [RW-1:0] c_rre  [NC+1];
    logic [RW-1:0] c_rim  [NC+1];
    logic [DW:0]   c_qre  [NC+1];
    logic [DW:0]   c_qim  [NC+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            c_v[0] <= 1'b0;
        end else if (adv) begin
            c_v[0] <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            c_side[0] <= n_side4;
            c_den[0]  <= r_den3;
            c_rre[0]  <= num_re_sh;
            c_rim[0]  <= num_im_sh;
            c_qre[0]  <= '0;
            c_qim[0]  <= '0;
        end
    end

    for (genvar g = 0; g < NC; g++) begin : g_cell
        cau_div_cell #(
            .DW    (DW),
            .PW    (PW),
            .RW    (RW),
            .SHIFT (DW - g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (adv),
            .i_valid  (c_v[g]),
            .i_side   (c_side[g]),
            .i_den    (c_den[g]),
            .i_rem_re (c_rre[g]),
            .i_rem_im (c_rim[g]),
            .i_q_re   (c_qre[g]),
            .i_q_im   (c_qim[g]),
            .o_valid  (c_v[g+1]),
            .o_side   (c_side[g+1]),
            .o_den    (c_den[g+1]),
            .o_rem_re (c_rre[g+1]),
            .o_rem_im (c_rim[g+1]),
            .o_q_re   (c_qre[g+1]),
            .o_q_im   (c_qim[g+1])
        );
    end

    // output stage: sign and saturate the quotients
    t_side              fs;
    logic signed [PW:0] qv_re, qv_im;
    logic [32:0]        s3_re, s3_im;
    t_out_item          n_out;

    assign fs = c_side[NC];

    always_comb begin
        qv_re = fs.neg_re ? -(PW+1)'(c_qre[NC]) : (PW+1)'(c_qre[NC]);
        qv_im = fs.neg_im ? -(PW+1)'(c_qim[NC]) : (PW+1)'(c_qim[NC]);
        // quotient beyond the chain's reach: force saturation
        if (fs.big_re) begin
            qv_re = fs.neg_re ? SMIN - (PW+1)'(1) : SMAX + (PW+1)'(1);
        end
        if (fs.big_im) begin
            qv_im = fs.neg_im ? SMIN - (PW+1)'(1) : SMAX + (PW+1)'(1);
        end
        s3_re = sat(qv_re);
        s3_im = sat(qv_im);

        n_out.res_re   = fs.res_re;
        n_out.res_im   = fs.res_im;
        n_out.equal    = fs.eq;
        n_out.div_zero = fs.dz;
        n_out.overflow = fs.ovf;
        if (fs.is_div) begin
            if (fs.dz) begin
                n_out.res_re   = '0;
                n_out.res_im   = '0;
                n_out.overflow = 1'b0;
            end else begin
                n_out.res_re   = s3_re[31:0];
                n_out.res_im   = s3_im[31:0];
                n_out.overflow = s3_re[32] | s3_im[32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= c_v[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_data <= n_out;
        end
    end

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.div_zero) |->
            (o_data.res_re == '0 && o_data.res_im == '0 && !o_data.overflow))
        else $error("division by zero result is not clean");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.equal && (o_data.div_zero || o_data.overflow)))
        else $error("compare flag raised with divide or overflow flag");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
